### rtl/epmb_pkg.sv
// epmb_pkg: shared constants, types and tables for the pose matrix builder.
// No dependencies.
`timescale 1ns / 1ps
package epmb_pkg;
    localparam int DEF_VALUE_WIDTH   = 32;
    localparam int DEF_CORDIC_STAGES = 16;
    localparam int ATAN_COUNT        = 24;
    localparam int ANG_W             = 16;
    localparam int TRIG_W            = 32;
    localparam int Z_W               = 32;
    localparam logic signed [TRIG_W-1:0] GAIN_Q30 = 32'sd652032874;
    localparam logic signed [ANG_W:0] TURN_UNITS   = 17'sd23040;
    localparam logic signed [ANG_W:0] HALF_TURN    = 17'sd11520;
    localparam logic signed [ANG_W:0] QUARTER_TURN = 17'sd5760;

    typedef struct packed {
        logic signed [TRIG_W-1:0] x;
        logic signed [TRIG_W-1:0] y;
        logic signed [Z_W-1:0]    z;
        logic                     neg;
    } t_rot;

    function automatic logic signed [Z_W-1:0] atan_units(input int i);
        logic signed [Z_W-1:0] v;
        begin
            case (i)
                0: v = 188743680;  1: v = 111421900; 2: v = 58872272;
                3: v = 29884485;   4: v = 15000234;  5: v = 7507429;
                6: v = 3754631;    7: v = 1877430;   8: v = 938729;
                9: v = 469366;     10: v = 234683;   11: v = 117342;
                12: v = 58671;     13: v = 29335;    14: v = 14668;
                15: v = 7334;      16: v = 3667;     17: v = 1833;
                18: v = 917;       19: v = 458;      20: v = 229;
                21: v = 115;       22: v = 57;       23: v = 29;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

    // Q30 x Q30 rounded product.
    function automatic logic signed [TRIG_W-1:0] mul30(
        input logic signed [TRIG_W-1:0] a, input logic signed [TRIG_W-1:0] b);
        logic signed [2*TRIG_W-1:0] p;
        begin
            p = a * b + 64'sd536870912;
            return p[TRIG_W+29:30];
        end
    endfunction
endpackage

### rtl/epmb_cordic_cell.sv
// epmb_cordic_cell: one CORDIC micro-rotation stage with a register.
// Depends on epmb_pkg.
`timescale 1ns / 1ps
module epmb_cordic_cell import epmb_pkg::*; #(
    parameter int STAGE = 0
) (
    input  logic i_clk,
    input  t_rot i_rot,
    output t_rot o_rot
);
    t_rot n_rot;
    t_rot r_rot;
    always_comb begin
        n_rot = i_rot;
        if (!i_rot.z[Z_W-1]) begin
            n_rot.x = i_rot.x - (i_rot.y >>> STAGE);
            n_rot.y = i_rot.y + (i_rot.x >>> STAGE);
            n_rot.z = i_rot.z - atan_units(STAGE);
        end else begin
            n_rot.x = i_rot.x + (i_rot.y >>> STAGE);
            n_rot.y = i_rot.y - (i_rot.x >>> STAGE);
            n_rot.z = i_rot.z + atan_units(STAGE);
        end
    end
    always_ff @(posedge i_clk) begin
        r_rot <= n_rot;
    end
    assign o_rot = r_rot;
endmodule

### rtl/epmb_sincos.sv
// epmb_sincos: angle reduction and a chain of CORDIC cells giving sine and cosine.
// Depends on epmb_pkg and epmb_cordic_cell.
`timescale 1ns / 1ps
module epmb_sincos import epmb_pkg::*; #(
    parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
    input  logic                     i_clk,
    input  logic signed [ANG_W-1:0]  i_angle,
    output logic signed [TRIG_W-1:0] o_sin,
    output logic signed [TRIG_W-1:0] o_cos
);
    localparam int NC = (CORDIC_STAGES < ATAN_COUNT) ? CORDIC_STAGES : ATAN_COUNT;
    t_rot chain [NC+1];
    t_rot r_in;
    t_rot n_in;
    logic signed [ANG_W:0] red;

    always_comb begin
        red = $signed({i_angle[ANG_W-1], i_angle});
        // wrap into (-180,180]; one step covers the whole 16-bit input
        if (red > HALF_TURN) red = red - TURN_UNITS;
        else if (red <= -HALF_TURN) red = red + TURN_UNITS;
        n_in.neg = 1'b0;
        if (red > QUARTER_TURN) begin
            red = red - HALF_TURN;
            n_in.neg = 1'b1;
        end else if (red < -QUARTER_TURN) begin
            red = red + HALF_TURN;
            n_in.neg = 1'b1;
        end
        n_in.x = GAIN_Q30;
        n_in.y = '0;
        n_in.z = Z_W'(red) <<< 16;
    end
    always_ff @(posedge i_clk) begin
        r_in <= n_in;
    end
    assign chain[0] = r_in;
    for (genvar g = 0; g < NC; g++) begin : g_cell
        epmb_cordic_cell #(.STAGE(g)) u_cell (
            .i_clk(i_clk), .i_rot(chain[g]), .o_rot(chain[g+1]));
    end
    assign o_sin = chain[NC].neg ? -chain[NC].y : chain[NC].y;
    assign o_cos = chain[NC].neg ? -chain[NC].x : chain[NC].x;
endmodule

### rtl/euler_pose_matrix_builder_top.sv
// Pose matrix builder top: three CORDIC chains, two product stages and an element shifter.
// Element 0 reaches the ports after the reduce register, one register per cell, the two
// product stages and the row load; the other elements follow one per cycle.
// busy rises after each accepted word and holds off start until the r_cnt countdown ends.
// Reset (synchronous, active low) clears the counters, slot pointers and valid pipeline.
// The receiver cannot stall: each element is shown for exactly one cycle.
`timescale 1ns / 1ps
module euler_pose_matrix_builder_top import epmb_pkg::*; #(
    parameter int VALUE_WIDTH   = DEF_VALUE_WIDTH,
    parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_scale_x,
    input  logic signed [31:0] i_scale_y,
    input  logic signed [31:0] i_scale_z,
    input  logic signed [31:0] i_shift_x,
    input  logic signed [31:0] i_shift_y,
    input  logic signed [31:0] i_shift_z,
    input  logic signed [15:0] i_yaw_deg,
    input  logic signed [15:0] i_pitch_deg,
    input  logic signed [15:0] i_roll_deg,
    output logic               o_valid,
    output logic [3:0]         o_element_index,
    output logic signed [31:0] o_element_value,
    output logic               o_last_element
);
    localparam int NC  = (CORDIC_STAGES < ATAN_COUNT) ? CORDIC_STAGES : ATAN_COUNT;
    localparam int LAT = NC + 1;       // reduce register plus one per cell
    localparam int PW  = 64;

    // Hold pose payload beside the CORDIC chain; angles go in directly.
    // Two slots: the chain is longer than one run, so two words can be in flight.
    logic signed [31:0] r_sc [2][3];
    logic signed [31:0] r_sh [2][3];
    logic r_wsel;              // slot written by the next accepted word
    logic r_rsel;              // slot read by the next row load
    logic [LAT-1:0] r_vpipe;
    logic [4:0] r_cnt;         // busy countdown over one run
    logic accept;

    assign accept = start && !busy;
    assign busy = (r_cnt != 5'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (accept) begin
            r_cnt <= 5'd15;
        end else if (r_cnt != 5'd0) begin
            r_cnt <= r_cnt - 5'd1;
        end
    end
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sc[r_wsel][0] <= i_scale_x;
            r_sc[r_wsel][1] <= i_scale_y;
            r_sc[r_wsel][2] <= i_scale_z;
            r_sh[r_wsel][0] <= i_shift_x;
            r_sh[r_wsel][1] <= i_shift_y;
            r_sh[r_wsel][2] <= i_shift_z;
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_wsel <= 1'b0;
        else if (accept) r_wsel <= !r_wsel;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vpipe <= '0;
        else          r_vpipe <= {r_vpipe[LAT-2:0], accept};
    end

    logic signed [TRIG_W-1:0] sa, ca, sb, cb, sg, cg;
    epmb_sincos #(.CORDIC_STAGES(CORDIC_STAGES)) u_yaw (
        .i_clk(i_clk), .i_angle(i_yaw_deg), .o_sin(sa), .o_cos(ca));
    epmb_sincos #(.CORDIC_STAGES(CORDIC_STAGES)) u_pitch (
        .i_clk(i_clk), .i_angle(i_pitch_deg), .o_sin(sb), .o_cos(cb));
    epmb_sincos #(.CORDIC_STAGES(CORDIC_STAGES)) u_roll (
        .i_clk(i_clk), .i_angle(i_roll_deg), .o_sin(sg), .o_cos(cg));

    // Stage A: first-level trig products.
    logic signed [TRIG_W-1:0] r_cacb, r_casb, r_sacb, r_sasb, r_sacg, r_sasg;
    logic signed [TRIG_W-1:0] r_cacg, r_casg, r_cbsg, r_cbcg, r_nsb, r_sg, r_cg;
    logic r_va;
    always_ff @(posedge i_clk) begin
        r_cacb <= mul30(ca, cb); r_casb <= mul30(ca, sb);
        r_sacb <= mul30(sa, cb); r_sasb <= mul30(sa, sb);
        r_sacg <= mul30(sa, cg); r_sasg <= mul30(sa, sg);
        r_cacg <= mul30(ca, cg); r_casg <= mul30(ca, sg);
        r_cbsg <= mul30(cb, sg); r_cbcg <= mul30(cb, cg);
        r_nsb  <= -sb; r_sg <= sg; r_cg <= cg;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_va <= 1'b0;
        else          r_va <= r_vpipe[LAT-1];
    end

    // Stage B: second-level products and sums give the nine rotation terms.
    logic signed [TRIG_W-1:0] r_t [9];
    logic r_vb;
    always_ff @(posedge i_clk) begin
        r_t[0] <= r_cacb;
        r_t[1] <= mul30(r_casb, r_sg) - r_sacg;
        r_t[2] <= mul30(r_casb, r_cg) + r_sasg;
        r_t[3] <= r_sacb;
        r_t[4] <= mul30(r_sasb, r_sg) + r_cacg;
        r_t[5] <= mul30(r_sasb, r_cg) - r_casg;
        r_t[6] <= r_nsb;
        r_t[7] <= r_cbsg;
        r_t[8] <= r_cbcg;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vb <= 1'b0;
        else          r_vb <= r_va;
    end

    // Stage C: scale and saturate the rotation terms, saturate the translations, load all 16 elements.
    function automatic logic signed [31:0] satv(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] hi;
        logic signed [PW-1:0] lo;
        logic signed [PW-1:0] r;
        begin
            hi = (PW'(1) <<< (VALUE_WIDTH - 1)) - PW'(1);
            lo = -hi - PW'(1);
            r = (v > hi) ? hi : ((v < lo) ? lo : v);
            return r[31:0];
        end
    endfunction
    function automatic logic signed [31:0] elemv(input logic signed [31:0] s,
                                                 input logic signed [TRIG_W-1:0] t);
        logic signed [PW-1:0] p;
        begin
            p = s * t + 64'sd536870912;
            return satv(p >>> 30);
        end
    endfunction

    logic signed [31:0] r_row [16];
    logic [4:0] r_left;   // elements still to emit
    logic [3:0] r_idx;
    always_ff @(posedge i_clk) begin
        if (r_vb) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_row[r*4+c] <= elemv(r_sc[r_rsel][c], r_t[r*3+c]);
                end
                r_row[r*4+3] <= satv(PW'(r_sh[r_rsel][r]));
            end
            r_row[12] <= '0; r_row[13] <= '0; r_row[14] <= '0;
            r_row[15] <= satv(PW'(65536));
        end else begin
            // advance the row one element per cycle
            for (int k = 0; k < 15; k++) r_row[k] <= r_row[k+1];
            r_row[15] <= '0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_rsel <= 1'b0;
        else if (r_vb) r_rsel <= !r_rsel;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_idx <= '0;
        end else if (r_vb) begin
            r_left <= 5'd16;
            r_idx <= '0;
        end else if (r_left != 5'd0) begin
            r_left <= r_left - 5'd1;
            r_idx <= r_idx + 4'd1;
        end
    end
    // r_row[0] is emitted in the cycle after load; index tracks it.
    assign o_valid         = (r_left != 5'd0);
    assign o_element_index = r_idx;
    assign o_element_value = r_row[0];
    assign o_last_element  = o_valid && (r_left == 5'd1);

    a_idx_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_element |-> o_element_index == 4'd15) else $error("last misplaced");
    a_busy_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy) else $error("busy not raised");
    a_run_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_element) |=> o_valid) else $error("run broken");
endmodule

### tb/tb.sv
// tb: self-checking bench for euler_pose_matrix_builder_top.
// Drives pose words through a start/busy handshake and checks all 16 matrix elements
// against an in-bench CORDIC predictor. Depends on rtl/epmb_pkg.sv and the top RTL.
`timescale 1ns / 1ps
module tb import epmb_pkg::*;;

    localparam int VW      = DEF_VALUE_WIDTH;
    localparam int STAGES  = DEF_CORDIC_STAGES;
    localparam int RAND_N  = 150;
    localparam int LIMIT   = 400000;
    localparam int DRAIN   = STAGES + 40;
    localparam longint HALF30 = 64'sd536870912;

    typedef struct {
        logic signed [31:0] sx, sy, sz, tx, ty, tz;
        logic signed [15:0] yaw, pitch, roll;
        bit                 fixed;   // directed row with typed-in translations
    } pose_t;

    typedef struct {
        logic [3:0]         idx;
        logic signed [31:0] value;
        logic               last;
    } elem_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [31:0] i_scale_x = '0, i_scale_y = '0, i_scale_z = '0;
    logic signed [31:0] i_shift_x = '0, i_shift_y = '0, i_shift_z = '0;
    logic signed [15:0] i_yaw_deg = '0, i_pitch_deg = '0, i_roll_deg = '0;
    logic               o_valid;
    logic [3:0]         o_element_index;
    logic signed [31:0] o_element_value;
    logic               o_last_element;

    elem_t  pending_elems[$];
    int     errors = 0;
    longint cycles = 0;

    euler_pose_matrix_builder_top dut (.*);

    always #4 i_clk = ~i_clk;

    // Floor shift for signed 64-bit values.
    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint q30_mul(longint a, longint b);
        return shr_floor(a * b + HALF30, 30);
    endfunction

    function automatic longint clamp_vw(longint v);
        longint hi, lo;
        hi = (64'sd1 <<< (VW - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic longint scaled_term(longint s, longint t);
        return clamp_vw(shr_floor(s * t + HALF30, 30));
    endfunction

    // Reduce the angle into (-180,180], fold into [-90,90], run the CORDIC.
    task automatic angle_sin_cos(input logic signed [15:0] ang,
                                 output longint sn, output longint cs);
        longint r, x, y, z, dx, dy;
        bit     flip;
        r = longint'(ang) % 23040;
        flip = 0;
        x = 652032874;
        y = 0;
        if (r < 0) r += 23040;
        if (r > 11520) r -= 23040;
        if (r > 5760) begin
            r -= 11520; flip = 1;
        end else if (r < -5760) begin
            r += 11520; flip = 1;
        end
        z = r * 65536;
        for (int i = 0; i < STAGES && i < ATAN_COUNT; i++) begin
            dx = shr_floor(y, i);
            dy = shr_floor(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(atan_units(i));
            end else begin
                x += dx; y -= dy; z += longint'(atan_units(i));
            end
        end
        sn = flip ? -y : y;
        cs = flip ? -x : x;
    endtask

    // Build the expected 16-element run for one pose word.
    task automatic predict_matrix(input pose_t p);
        longint sa, ca, sb, cb, sg, cg;
        longint m[16];
        elem_t  e;
        angle_sin_cos(p.yaw, sa, ca);
        angle_sin_cos(p.pitch, sb, cb);
        angle_sin_cos(p.roll, sg, cg);
        m[0]  = scaled_term(p.sx, q30_mul(ca, cb));
        m[1]  = scaled_term(p.sy, q30_mul(q30_mul(ca, sb), sg) - q30_mul(sa, cg));
        m[2]  = scaled_term(p.sz, q30_mul(q30_mul(ca, sb), cg) + q30_mul(sa, sg));
        m[3]  = clamp_vw(p.tx);
        m[4]  = scaled_term(p.sx, q30_mul(sa, cb));
        m[5]  = scaled_term(p.sy, q30_mul(q30_mul(sa, sb), sg) + q30_mul(ca, cg));
        m[6]  = scaled_term(p.sz, q30_mul(q30_mul(sa, sb), cg) - q30_mul(ca, sg));
        m[7]  = clamp_vw(p.ty);
        m[8]  = scaled_term(p.sx, -sb);
        m[9]  = scaled_term(p.sy, q30_mul(cb, sg));
        m[10] = scaled_term(p.sz, q30_mul(cb, cg));
        m[11] = clamp_vw(p.tz);
        m[12] = 0;
        m[13] = 0;
        m[14] = 0;
        m[15] = clamp_vw(65536);
        if (p.fixed) begin
            // Translations read straight off the pose; the last element is 65536, unclamped.
            m[3] = p.tx; m[7] = p.ty; m[11] = p.tz; m[15] = 65536;
        end
        for (int k = 0; k < 16; k++) begin
            e.idx   = 4'(k);
            e.value = m[k][31:0];
            e.last  = (k == 15);
            pending_elems.push_back(e);
        end
    endtask

    function automatic logic signed [15:0] rand_angle();
        case ($urandom_range(0, 3))
            0: return 16'($signed($urandom_range(0, 46080)) - 23040);
            1: return 16'($signed($urandom_range(0, 64)) - 32);  // near zero
            2: return 16'(($urandom_range(0, 8) - 4) * 2880);    // 45 degree grid
            default: return 16'($urandom);                      // full 16-bit range
        endcase
    endfunction

    function automatic logic signed [31:0] rand_q16();
        case ($urandom_range(0, 3))
            0: return 32'($signed($urandom_range(0, 8 * 65536)) - 4 * 65536);
            1: return 32'sh7fffffff;
            2: return 32'sh80000000;
            default: return $urandom;
        endcase
    endfunction

    // Hold start for one word until busy is low at a rising edge.
    task automatic send_pose(input pose_t p, input bit allow_gap);
        if (allow_gap) begin
            // idle only in cycles where the block could take a word
            while (busy) @(negedge i_clk);
            while ($urandom_range(0, 99) < 35) @(negedge i_clk);
        end
        i_scale_x = p.sx; i_scale_y = p.sy; i_scale_z = p.sz;
        i_shift_x = p.tx; i_shift_y = p.ty; i_shift_z = p.tz;
        i_yaw_deg = p.yaw; i_pitch_deg = p.pitch; i_roll_deg = p.roll;
        start = 1'b1;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        predict_matrix(p);
        @(negedge i_clk);
        start = 1'b0;
    endtask

    // Check every strobed element against the oldest expectation.
    always @(posedge i_clk) begin
        elem_t e;
        if (i_rst_n && o_valid) begin
            if (pending_elems.size() == 0) begin
                $error("unexpected element idx=%0d value=%h", o_element_index,
                       o_element_value);
                errors++;
            end else begin
                e = pending_elems.pop_front();
                if (o_element_index !== e.idx) begin
                    $error("element_index expected %0d actual %0d", e.idx,
                           o_element_index);
                    errors++;
                end
                if (o_element_value !== e.value) begin
                    $error("element_value [%0d] expected %h actual %h", e.idx, e.value,
                           o_element_value);
                    errors++;
                end
                if (o_last_element !== e.last) begin
                    $error("last_element [%0d] expected %0b actual %0b", e.idx, e.last,
                           o_last_element);
                    errors++;
                end
            end
        end
    end

    // Bound the run.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        pose_t dir_rows[$];
        pose_t p;
        logic signed [15:0] ang_cases[12];
        ang_cases = '{16'sd0, 16'sd5760, -16'sd5760, 16'sd11520, -16'sd11520, 16'sd23040,
                      -16'sd23040, 16'sd5761, -16'sd5761, 16'sd2880, 16'sd32767,
                      16'sh8000};
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed rows: identity, angle extremes and folds, saturating scales.
        p = '{32'sh10000, 32'sh10000, 32'sh10000, 0, 0, 0, 0, 0, 0, 1};
        dir_rows.push_back(p);
        p = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
              32'sh7fffffff, 0, 0, 0, 1};
        dir_rows.push_back(p);
        p = '{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7fffffff,
              32'sh80000000, 16'sd11520, 16'sd11520, 16'sd11520, 1};
        dir_rows.push_back(p);
        p = '{32'shffffffff, 32'h0, 32'h1, 32'hffffffff, 32'h1, 32'h0, -16'sd1, 16'sd1,
              16'sd0, 1};
        dir_rows.push_back(p);
        foreach (ang_cases[i]) begin
            p = '{32'sh7fffffff, 32'sh80000000, 32'sh20000, 32'sh12345678, 32'shedcba987,
                  32'sh0, ang_cases[i], ang_cases[(i + 3) % 12], ang_cases[(i + 7) % 12], 1};
            dir_rows.push_back(p);
        end
        foreach (dir_rows[i]) send_pose(dir_rows[i], 0);

        // Random poses; the second half runs without gaps.
        for (int n = 0; n < RAND_N; n++) begin
            p.sx = rand_q16(); p.sy = rand_q16(); p.sz = rand_q16();
            p.tx = rand_q16(); p.ty = rand_q16(); p.tz = rand_q16();
            p.yaw = rand_angle(); p.pitch = rand_angle(); p.roll = rand_angle();
            p.fixed = 0;
            send_pose(p, n < RAND_N / 2);
        end

        while (pending_elems.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (errors == 0 && pending_elems.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

### files.f
rtl/epmb_pkg.sv
rtl/epmb_cordic_cell.sv
rtl/epmb_sincos.sv
rtl/euler_pose_matrix_builder_top.sv
tb/tb.sv
